// ===== hw/rtl/rhc_pkg.sv =====
`default_nettype none

package rhc_pkg;

    localparam int PIX_W    = 8;
    localparam int HUE_W    = 15;
    localparam int SAT_W    = 13;
    localparam int HUE_QW   = 15;
    localparam int SAT_QW   = 13;
    localparam int NUM_W    = 23;
    localparam int SNUM_W   = PIX_W + 12;

    localparam int HUE_SIXTH = 3840;
    localparam int HUE_TURN  = 23040;
    localparam int SAT_ONE   = 4096;

    localparam int PIPE_LAT = HUE_QW + 3;

    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

    typedef struct packed {
        logic              zero;
        logic [PIX_W-1:0]  bright;
        logic [PIX_W-1:0]  hdvs;
        logic [PIX_W-1:0]  hrem;
        logic [HUE_QW-1:0] hw;
        logic [PIX_W-1:0]  srem;
        logic [SAT_QW-1:0] sw;
    } t_div;

    function automatic logic [PIX_W:0] div_step(
        input logic [PIX_W-1:0] rem,
        input logic             nb,
        input logic [PIX_W-1:0] dvs
    );
        logic [PIX_W:0] t;
        logic [PIX_W:0] d;
        t = {rem, nb};
        d = t - {1'b0, dvs};
        if (t >= {1'b0, dvs}) begin
            div_step = {1'b1, d[PIX_W-1:0]};
        end else begin
            div_step = {1'b0, t[PIX_W-1:0]};
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_to_hsv_converter.sv =====
`default_nettype none

// Channel   Signals                                  Direction  Handshake
// command   start, busy, i_red, i_green, i_blue      in         start && !busy
// result    o_valid, o_hue, o_saturation,            out        o_valid strobe, one cycle
//           o_brightness
//
// One pixel per clock sustained; busy is always low.
// The hue quotient takes 15 restoring-division stages, one quotient bit per
// stage, with the saturation quotient (13 bits) riding in the same stages.
// Reset clears only the valid bits of the pipeline and the result strobe.
// The receiver cannot stall, so the pipeline never holds.

module rgb_to_hsv_converter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [rhc_pkg::PIX_W-1:0]   i_red,
    input  logic [rhc_pkg::PIX_W-1:0]   i_green,
    input  logic [rhc_pkg::PIX_W-1:0]   i_blue,
    output logic                        o_valid,
    output logic [rhc_pkg::HUE_W-1:0]   o_hue,
    output logic [rhc_pkg::SAT_W-1:0]   o_saturation,
    output logic [rhc_pkg::PIX_W-1:0]   o_brightness
);
    import rhc_pkg::*;

    logic                r_s1_vld;
    t_sector             r_s1_sec;
    logic [PIX_W-1:0]    r_s1_max;
    logic [PIX_W-1:0]    r_s1_delta;
    logic signed [PIX_W:0] r_s1_diff;

    t_sector             n_s1_sec;
    logic [PIX_W-1:0]    n_s1_max;
    logic [PIX_W-1:0]    n_s1_min;
    logic signed [PIX_W:0] n_s1_diff;

    logic [HUE_QW:0]     r_dvld;
    t_div                r_dv [0:HUE_QW];
    t_div                n_dv_head;
    t_div                n_dv [1:HUE_QW];

    logic [HUE_W-1:0]    n_base;
    logic [NUM_W-1:0]    n_bxd;
    logic signed [NUM_W+1:0] n_sx;
    logic signed [NUM_W+1:0] n_num;
    logic [SNUM_W-1:0]   n_snum;

    logic                r_out_vld;
    logic [HUE_W-1:0]    r_hue;
    logic [SAT_W-1:0]    r_sat;
    logic [PIX_W-1:0]    r_bright;
    logic [HUE_W-1:0]    n_hue;
    logic [SAT_W-1:0]    n_sat;

    assign busy = 1'b0;

    // max / min with red, green, blue priority on ties
    always_comb begin
        if (i_red >= i_green && i_red >= i_blue) begin
            n_s1_sec  = SEC_RED;
            n_s1_max  = i_red;
            n_s1_diff = $signed({1'b0, i_green}) - $signed({1'b0, i_blue});
        end else if (i_green >= i_blue) begin
            n_s1_sec  = SEC_GREEN;
            n_s1_max  = i_green;
            n_s1_diff = $signed({1'b0, i_blue}) - $signed({1'b0, i_red});
        end else begin
            n_s1_sec  = SEC_BLUE;
            n_s1_max  = i_blue;
            n_s1_diff = $signed({1'b0, i_red}) - $signed({1'b0, i_green});
        end
        n_s1_min = i_red;
        if (i_green < n_s1_min) begin
            n_s1_min = i_green;
        end
        if (i_blue < n_s1_min) begin
            n_s1_min = i_blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_sec   <= n_s1_sec;
        r_s1_max   <= n_s1_max;
        r_s1_delta <= n_s1_max - n_s1_min;
        r_s1_diff  <= n_s1_diff;
    end

    // hue numerator: sector base times delta plus one sixth times the difference
    always_comb begin
        case (r_s1_sec)
            SEC_RED: begin
                n_base = r_s1_diff < 0 ? HUE_W'(HUE_TURN) : '0;
            end
            SEC_GREEN: begin
                n_base = HUE_W'(2 * HUE_SIXTH);
            end
            SEC_BLUE: begin
                n_base = HUE_W'(4 * HUE_SIXTH);
            end
            default: begin
                n_base = '0;
            end
        endcase
        n_bxd  = NUM_W'(n_base) * NUM_W'(r_s1_delta);
        n_sx   = $signed((NUM_W+2)'(HUE_SIXTH)) * (NUM_W+2)'(r_s1_diff);
        n_num  = $signed({2'b00, n_bxd}) + n_sx;
        n_snum = {r_s1_delta, 12'b0};

        n_dv_head.zero   = r_s1_delta == '0;
        n_dv_head.bright = r_s1_max;
        n_dv_head.hdvs   = r_s1_delta;
        n_dv_head.hrem   = n_num[NUM_W-1:HUE_QW];
        n_dv_head.hw     = n_num[HUE_QW-1:0];
        n_dv_head.srem   = PIX_W'(n_snum[SNUM_W-1:SAT_QW]);
        n_dv_head.sw     = n_snum[SAT_QW-1:0];
    end

    // one quotient bit per stage for both dividers
    always_comb begin
        logic [PIX_W:0] hs;
        logic [PIX_W:0] ss;
        for (int k = 1; k <= HUE_QW; k++) begin
            n_dv[k] = r_dv[k-1];
            hs = div_step(r_dv[k-1].hrem, r_dv[k-1].hw[HUE_QW-1], r_dv[k-1].hdvs);
            n_dv[k].hrem = hs[PIX_W-1:0];
            n_dv[k].hw   = {r_dv[k-1].hw[HUE_QW-2:0], hs[PIX_W]};
            if (k <= SAT_QW) begin
                ss = div_step(r_dv[k-1].srem, r_dv[k-1].sw[SAT_QW-1],
                              r_dv[k-1].bright);
                n_dv[k].srem = ss[PIX_W-1:0];
                n_dv[k].sw   = {r_dv[k-1].sw[SAT_QW-2:0], ss[PIX_W]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld <= '0;
        end else begin
            r_dvld <= {r_dvld[HUE_QW-1:0], r_s1_vld};
        end
        r_dv[0] <= n_dv_head;
        for (int k = 1; k <= HUE_QW; k++) begin
            r_dv[k] <= n_dv[k];
        end
    end

    // wrap and gray override
    always_comb begin
        if (r_dv[HUE_QW].zero) begin
            n_hue = '0;
            n_sat = '0;
        end else begin
            n_sat = r_dv[HUE_QW].sw;
            if (r_dv[HUE_QW].hw >= HUE_W'(HUE_TURN)) begin
                n_hue = r_dv[HUE_QW].hw - HUE_W'(HUE_TURN);
            end else begin
                n_hue = r_dv[HUE_QW].hw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_dvld[HUE_QW];
        end
        r_hue    <= n_hue;
        r_sat    <= n_sat;
        r_bright <= r_dv[HUE_QW].bright;
    end

    assign o_valid      = r_out_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bright;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("item lost in pipeline");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HUE_W'(HUE_TURN)))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= SAT_W'(SAT_ONE)))
        else $error("saturation out of range");

    a_gray: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_saturation == '0) |-> (o_hue == '0))
        else $error("gray pixel with nonzero hue");

endmodule

`default_nettype wire

// ===== test/rgb_to_hsv_converter_tb.sv =====
`timescale 1ns / 100ps

module rgb_to_hsv_converter_tb;

    import rhc_pkg::*;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic [SAT_W-1:0] sat;
        logic [PIX_W-1:0] bright;
    } t_hsv;

    typedef struct packed {
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic             typed;
        t_hsv             hsv;
    } t_pix_row;

    localparam int NUM_ROWS     = 21;
    localparam int NUM_RANDOM   = 450;
    localparam int MAX_REPORTED = 10;

    localparam t_pix_row PIX_ROWS [0:NUM_ROWS-1] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     13'd0,    8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     13'd0,    8'd255}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     13'd0,    8'd1}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     13'd0,    8'd128}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     13'd4096, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  13'd4096, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 13'd4096, 8'd255}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{15'd3840,  13'd4096, 8'd255}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{15'd11520, 13'd4096, 8'd255}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{15'd19200, 13'd4096, 8'd255}},
        '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     13'd4096, 8'd1}},
        '{8'd255, 8'd0,   8'd1,   1'b0, '0},
        '{8'd255, 8'd254, 8'd254, 1'b0, '0},
        '{8'd254, 8'd255, 8'd254, 1'b0, '0},
        '{8'd254, 8'd254, 8'd255, 1'b0, '0},
        '{8'd200, 8'd100, 8'd50,  1'b0, '0},
        '{8'd50,  8'd200, 8'd100, 1'b0, '0},
        '{8'd100, 8'd50,  8'd200, 1'b0, '0},
        '{8'd170, 8'd85,  8'd85,  1'b0, '0},
        '{8'd85,  8'd170, 8'd170, 1'b0, '0},
        '{8'd3,   8'd1,   8'd2,   1'b0, '0}
    };

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [PIX_W-1:0] i_red;
    logic [PIX_W-1:0] i_green;
    logic [PIX_W-1:0] i_blue;
    logic             o_valid;
    logic [HUE_W-1:0] o_hue;
    logic [SAT_W-1:0] o_saturation;
    logic [PIX_W-1:0] o_brightness;

    t_hsv pending_hsv [$];
    int   mismatches;
    bit   burst;

    rgb_to_hsv_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_hsv rgb_to_hsv(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                                        input logic [PIX_W-1:0] b);
        int   ri;
        int   gi;
        int   bi;
        int   mx;
        int   mn;
        int   delta;
        int   num;
        t_hsv res;
        ri = int'(r);
        gi = int'(g);
        bi = int'(b);
        mx = ri;
        mn = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        delta = mx - mn;
        res = '0;
        res.bright = mx[PIX_W-1:0];
        if (delta > 0) begin
            res.sat = SAT_W'((delta * SAT_ONE) / mx);
            if (ri == mx) begin
                num = HUE_SIXTH * (gi - bi);
                if (num < 0) num += HUE_TURN * delta;
            end else if (gi == mx) begin
                num = 2 * HUE_SIXTH * delta + HUE_SIXTH * (bi - ri);
            end else begin
                num = 4 * HUE_SIXTH * delta + HUE_SIXTH * (ri - gi);
            end
            num = num / delta;
            if (num >= HUE_TURN) num -= HUE_TURN;
            res.hue = HUE_W'(num);
        end
        return res;
    endfunction

    task automatic idle_gap();
        int unsigned gap;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) begin
                i_red   = PIX_W'($urandom);
                i_green = PIX_W'($urandom);
                i_blue  = PIX_W'($urandom);
                @(negedge i_clk);
            end
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] b, input logic typed, input t_hsv hsv);
        start   = 1'b1;
        i_red   = r;
        i_green = g;
        i_blue  = b;
        do @(posedge i_clk); while (busy);
        pending_hsv.push_back(typed ? hsv : rgb_to_hsv(r, g, b));
        @(negedge i_clk);
        idle_gap();
    endtask

    always @(posedge i_clk) begin
        t_hsv want;
        if (i_rst_n && o_valid) begin
            if (pending_hsv.size() == 0) begin
                if (mismatches < MAX_REPORTED)
                    $display("unexpected item: hue %0d sat %0d bright %0d",
                             o_hue, o_saturation, o_brightness);
                mismatches++;
            end else begin
                want = pending_hsv.pop_front();
                if (want.hue !== o_hue || want.sat !== o_saturation ||
                    want.bright !== o_brightness) begin
                    if (mismatches < MAX_REPORTED)
                        $display("mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 want.hue, want.sat, want.bright,
                                 o_hue, o_saturation, o_brightness);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #2ms;
        $display("[rgb_to_hsv_converter] ERROR");
        $finish;
    end

    initial begin
        logic [PIX_W-1:0] r;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] top;
        int unsigned      kind;
        mismatches = 0;
        burst      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_red      = '0;
        i_green    = '0;
        i_blue     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NUM_ROWS; i++)
            send_pixel(PIX_ROWS[i].r, PIX_ROWS[i].g, PIX_ROWS[i].b,
                       PIX_ROWS[i].typed, PIX_ROWS[i].hsv);

        for (int i = 0; i < NUM_RANDOM; i++) begin
            kind = $urandom_range(0, 99);
            r = PIX_W'($urandom);
            g = PIX_W'($urandom);
            b = PIX_W'($urandom);
            if (kind < 10) begin
                g = r;
                b = r;
            end else if (kind < 25) begin
                top = PIX_W'($urandom_range(1, 255));
                case ($urandom_range(0, 2))
                    0: begin
                        r = top;
                        g = top;
                        b = PIX_W'($urandom_range(0, top));
                    end
                    1: begin
                        g = top;
                        b = top;
                        r = PIX_W'($urandom_range(0, top));
                    end
                    default: begin
                        r = top;
                        b = top;
                        g = PIX_W'($urandom_range(0, top));
                    end
                endcase
            end else if (kind < 40) begin
                top = PIX_W'($urandom_range(2, 255));
                r = top - PIX_W'($urandom_range(0, 1));
                g = top - PIX_W'($urandom_range(0, 1));
                b = top - PIX_W'($urandom_range(0, 2));
            end
            send_pixel(r, g, b, 1'b0, '0);
        end

        start = 1'b0;
        while (pending_hsv.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (mismatches == 0 && pending_hsv.size() == 0) begin
            $display("[rgb_to_hsv_converter] OK");
        end else begin
            $display("[rgb_to_hsv_converter] ERROR");
        end
        $finish;
    end

endmodule
